// ===== src/assert_macros.svh =====
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock edge, switched off while reset is low.
`define ASSERT_RST(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Concurrent assertion sampled on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// ===== src/mmcf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmcf_pkg
// Types and constants of the multicycle MIPS control unit.
// ----------------------------------------------------------------------------
package mmcf_pkg;

  // Opcodes and funct codes that the decode state recognises.
  localparam logic [5:0] OP_LW    = 6'b100011;
  localparam logic [5:0] OP_SW    = 6'b101011;
  localparam logic [5:0] OP_RTYPE = 6'b000000;
  localparam logic [5:0] OP_J     = 6'b000010;
  localparam logic [5:0] OP_BEQ   = 6'b000100;
  localparam logic [5:0] OP_ADDIU = 6'b001001;
  localparam logic [5:0] OP_ANDI  = 6'b001100;
  localparam logic [5:0] OP_LUI   = 6'b001111;
  localparam logic [5:0] OP_ORI   = 6'b001101;
  localparam logic [5:0] FN_SLL   = 6'b000000;
  localparam logic [5:0] FN_SRL   = 6'b000010;

  // Control states, one-hot.
  typedef enum logic [16:0] {
    ST_FETCH      = 17'h00001,
    ST_DECODE     = 17'h00002,
    ST_MEM_ADDR   = 17'h00004,
    ST_MEM_READ   = 17'h00008,
    ST_MEM_WB     = 17'h00010,
    ST_MEM_WRITE  = 17'h00020,
    ST_R_EXEC     = 17'h00040,
    ST_R_DONE     = 17'h00080,
    ST_BRANCH     = 17'h00100,
    ST_JUMP       = 17'h00200,
    ST_ADDIU_EXEC = 17'h00400,
    ST_IMM_DONE   = 17'h00800,
    ST_ANDI_EXEC  = 17'h01000,
    ST_LUI_EXEC   = 17'h02000,
    ST_ORI_EXEC   = 17'h04000,
    ST_SHIFT_EXEC = 17'h08000,
    ST_SHIFT_DONE = 17'h10000
  } state_e;

  // Mux selects and path flag that persist from one tick to the next.
  typedef struct packed {
    logic [2:0] alu_op;
    logic [1:0] alu_src_a;
    logic [1:0] alu_src_b;
    logic [1:0] pc_source;
    logic       iord;
    logic       reg_dst;
    logic       path_is_store;
  } hold_t;

  localparam hold_t HOLD_RESET = '{
    alu_op:        3'd0,
    alu_src_a:     2'd0,
    alu_src_b:     2'd1,
    pc_source:     2'd0,
    iord:          1'b0,
    reg_dst:       1'b0,
    path_is_store: 1'b0
  };

  typedef struct packed {
    logic [5:0] opcode;
    logic [5:0] funct_code;
  } in_t;

  typedef struct packed {
    logic [4:0] state_id;
    logic [2:0] alu_op;
    logic [1:0] alu_src_a;
    logic [1:0] alu_src_b;
    logic [1:0] pc_source;
    logic [2:0] memory_controls;
    logic [1:0] pc_controls;
    logic [2:0] register_controls;
    logic       ir_write;
  } out_t;

endpackage

// ===== src/mmcf_next.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmcf_next
// Next-state and control decode: from the current state, the held selects
// and one tick's instruction fields, works out the state entered and its
// control signals.
// ----------------------------------------------------------------------------
module mmcf_next (
  input  mmcf_pkg::state_e state_q_i,
  input  mmcf_pkg::hold_t  hold_q_i,
  input  mmcf_pkg::in_t    in_data_i,
  output mmcf_pkg::state_e state_d_o,
  output mmcf_pkg::hold_t  hold_d_o,
  output mmcf_pkg::out_t   result_o
);

  localparam logic [2:0] ALU_ADD   = 3'd0;
  localparam logic [2:0] ALU_SUB   = 3'd1;
  localparam logic [2:0] ALU_FUNCT = 3'd2;
  localparam logic [2:0] ALU_AND   = 3'd3;
  localparam logic [2:0] ALU_LUI   = 3'd4;
  localparam logic [2:0] ALU_OR    = 3'd5;

  localparam logic [1:0] SRCA_PC    = 2'd0;
  localparam logic [1:0] SRCA_REG   = 2'd1;
  localparam logic [1:0] SRCA_SHAMT = 2'd2;

  localparam logic [1:0] SRCB_REG    = 2'd0;
  localparam logic [1:0] SRCB_FOUR   = 2'd1;
  localparam logic [1:0] SRCB_IMM    = 2'd2;
  localparam logic [1:0] SRCB_BRANCH = 2'd3;

  localparam logic [1:0] PCS_ALU    = 2'd0;
  localparam logic [1:0] PCS_ALUOUT = 2'd1;
  localparam logic [1:0] PCS_JUMP   = 2'd2;

  function automatic logic [4:0] state_num(mmcf_pkg::state_e st);
    logic [4:0] n;
    case (st)
      mmcf_pkg::ST_FETCH:      n = 5'd0;
      mmcf_pkg::ST_DECODE:     n = 5'd1;
      mmcf_pkg::ST_MEM_ADDR:   n = 5'd2;
      mmcf_pkg::ST_MEM_READ:   n = 5'd3;
      mmcf_pkg::ST_MEM_WB:     n = 5'd4;
      mmcf_pkg::ST_MEM_WRITE:  n = 5'd5;
      mmcf_pkg::ST_R_EXEC:     n = 5'd6;
      mmcf_pkg::ST_R_DONE:     n = 5'd7;
      mmcf_pkg::ST_BRANCH:     n = 5'd8;
      mmcf_pkg::ST_JUMP:       n = 5'd9;
      mmcf_pkg::ST_ADDIU_EXEC: n = 5'd10;
      mmcf_pkg::ST_IMM_DONE:   n = 5'd11;
      mmcf_pkg::ST_ANDI_EXEC:  n = 5'd12;
      mmcf_pkg::ST_LUI_EXEC:   n = 5'd13;
      mmcf_pkg::ST_ORI_EXEC:   n = 5'd14;
      mmcf_pkg::ST_SHIFT_EXEC: n = 5'd15;
      mmcf_pkg::ST_SHIFT_DONE: n = 5'd16;
      default:                 n = 5'd0;
    endcase
    return n;
  endfunction

  mmcf_pkg::state_e nxt;
  mmcf_pkg::hold_t  hold;
  logic mem_rd, mem_wr, pc_cond, pc_wr, reg_wr, mem_to_reg, ir_wr;

  always_comb begin
    nxt  = mmcf_pkg::ST_FETCH;
    hold = hold_q_i;

    case (state_q_i)
      mmcf_pkg::ST_FETCH: begin
        nxt = mmcf_pkg::ST_DECODE;
      end
      mmcf_pkg::ST_DECODE: begin
        hold.path_is_store = 1'b0;
        case (in_data_i.opcode)
          mmcf_pkg::OP_LW: nxt = mmcf_pkg::ST_MEM_ADDR;
          mmcf_pkg::OP_SW: begin
            nxt                = mmcf_pkg::ST_MEM_ADDR;
            hold.path_is_store = 1'b1;
          end
          mmcf_pkg::OP_RTYPE: begin
            if (in_data_i.funct_code == mmcf_pkg::FN_SLL ||
                in_data_i.funct_code == mmcf_pkg::FN_SRL) begin
              nxt = mmcf_pkg::ST_SHIFT_EXEC;
            end else begin
              nxt = mmcf_pkg::ST_R_EXEC;
            end
          end
          mmcf_pkg::OP_BEQ:   nxt = mmcf_pkg::ST_BRANCH;
          mmcf_pkg::OP_J:     nxt = mmcf_pkg::ST_JUMP;
          mmcf_pkg::OP_ADDIU: nxt = mmcf_pkg::ST_ADDIU_EXEC;
          mmcf_pkg::OP_ANDI:  nxt = mmcf_pkg::ST_ANDI_EXEC;
          mmcf_pkg::OP_LUI:   nxt = mmcf_pkg::ST_LUI_EXEC;
          mmcf_pkg::OP_ORI:   nxt = mmcf_pkg::ST_ORI_EXEC;
          default:            nxt = mmcf_pkg::ST_FETCH;
        endcase
      end
      mmcf_pkg::ST_MEM_ADDR: begin
        nxt = hold_q_i.path_is_store ? mmcf_pkg::ST_MEM_WRITE : mmcf_pkg::ST_MEM_READ;
      end
      mmcf_pkg::ST_MEM_READ:   nxt = mmcf_pkg::ST_MEM_WB;
      mmcf_pkg::ST_R_EXEC:     nxt = mmcf_pkg::ST_R_DONE;
      mmcf_pkg::ST_ADDIU_EXEC: nxt = mmcf_pkg::ST_IMM_DONE;
      mmcf_pkg::ST_ANDI_EXEC:  nxt = mmcf_pkg::ST_IMM_DONE;
      mmcf_pkg::ST_LUI_EXEC:   nxt = mmcf_pkg::ST_IMM_DONE;
      mmcf_pkg::ST_ORI_EXEC:   nxt = mmcf_pkg::ST_IMM_DONE;
      mmcf_pkg::ST_SHIFT_EXEC: nxt = mmcf_pkg::ST_SHIFT_DONE;
      default:                 nxt = mmcf_pkg::ST_FETCH;
    endcase
  end

  // Strobes start cleared on every tick; selects keep their value unless the
  // state entered drives them.
  always_comb begin
    hold_d_o   = hold;
    mem_rd     = 1'b0;
    mem_wr     = 1'b0;
    pc_cond    = 1'b0;
    pc_wr      = 1'b0;
    reg_wr     = 1'b0;
    mem_to_reg = 1'b0;
    ir_wr      = 1'b0;

    case (nxt)
      mmcf_pkg::ST_FETCH: begin
        mem_rd             = 1'b1;
        ir_wr              = 1'b1;
        pc_wr              = 1'b1;
        hold_d_o.iord      = 1'b0;
        hold_d_o.alu_op    = ALU_ADD;
        hold_d_o.alu_src_a = SRCA_PC;
        hold_d_o.alu_src_b = SRCB_FOUR;
        hold_d_o.pc_source = PCS_ALU;
      end
      mmcf_pkg::ST_DECODE: begin
        hold_d_o.alu_op    = ALU_ADD;
        hold_d_o.alu_src_a = SRCA_PC;
        hold_d_o.alu_src_b = SRCB_BRANCH;
      end
      mmcf_pkg::ST_MEM_ADDR, mmcf_pkg::ST_ADDIU_EXEC: begin
        hold_d_o.alu_op    = ALU_ADD;
        hold_d_o.alu_src_a = SRCA_REG;
        hold_d_o.alu_src_b = SRCB_IMM;
      end
      mmcf_pkg::ST_MEM_READ: begin
        mem_rd        = 1'b1;
        hold_d_o.iord = 1'b1;
      end
      mmcf_pkg::ST_MEM_WB: begin
        reg_wr           = 1'b1;
        mem_to_reg       = 1'b1;
        hold_d_o.reg_dst = 1'b0;
      end
      mmcf_pkg::ST_MEM_WRITE: begin
        mem_wr        = 1'b1;
        hold_d_o.iord = 1'b1;
      end
      mmcf_pkg::ST_R_EXEC: begin
        hold_d_o.alu_op    = ALU_FUNCT;
        hold_d_o.alu_src_a = SRCA_REG;
        hold_d_o.alu_src_b = SRCB_REG;
      end
      mmcf_pkg::ST_R_DONE, mmcf_pkg::ST_SHIFT_DONE: begin
        reg_wr           = 1'b1;
        hold_d_o.reg_dst = 1'b1;
      end
      mmcf_pkg::ST_BRANCH: begin
        pc_cond            = 1'b1;
        hold_d_o.alu_op    = ALU_SUB;
        hold_d_o.alu_src_a = SRCA_REG;
        hold_d_o.alu_src_b = SRCB_REG;
        hold_d_o.pc_source = PCS_ALUOUT;
      end
      mmcf_pkg::ST_JUMP: begin
        pc_wr              = 1'b1;
        hold_d_o.pc_source = PCS_JUMP;
      end
      mmcf_pkg::ST_IMM_DONE: begin
        reg_wr           = 1'b1;
        hold_d_o.reg_dst = 1'b0;
      end
      mmcf_pkg::ST_ANDI_EXEC: begin
        hold_d_o.alu_op    = ALU_AND;
        hold_d_o.alu_src_a = SRCA_REG;
        hold_d_o.alu_src_b = SRCB_IMM;
      end
      mmcf_pkg::ST_LUI_EXEC: begin
        hold_d_o.alu_op    = ALU_LUI;
        hold_d_o.alu_src_a = SRCA_REG;
        hold_d_o.alu_src_b = SRCB_IMM;
      end
      mmcf_pkg::ST_ORI_EXEC: begin
        hold_d_o.alu_op    = ALU_OR;
        hold_d_o.alu_src_a = SRCA_REG;
        hold_d_o.alu_src_b = SRCB_IMM;
      end
      mmcf_pkg::ST_SHIFT_EXEC: begin
        hold_d_o.alu_op    = ALU_FUNCT;
        hold_d_o.alu_src_a = SRCA_SHAMT;
        hold_d_o.alu_src_b = SRCB_IMM;
      end
      default: begin
        hold_d_o = hold;
      end
    endcase
  end

  assign state_d_o = nxt;

  always_comb begin
    result_o.state_id          = state_num(nxt);
    result_o.alu_op            = hold_d_o.alu_op;
    result_o.alu_src_a         = hold_d_o.alu_src_a;
    result_o.alu_src_b         = hold_d_o.alu_src_b;
    result_o.pc_source         = hold_d_o.pc_source;
    result_o.memory_controls   = {hold_d_o.iord, mem_rd, mem_wr};
    result_o.pc_controls       = {pc_cond, pc_wr};
    result_o.register_controls = {reg_wr, mem_to_reg, hold_d_o.reg_dst};
    result_o.ir_write          = ir_wr;
  end

endmodule

// ===== src/multicycle_mips_control_fsm_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multicycle_mips_control_fsm_unit
// Control state machine of a multicycle MIPS datapath, one clock tick of the
// datapath per input transfer.
// ----------------------------------------------------------------------------
// Usage:
// Each input transfer carries the opcode and funct fields of the instruction
// and stands for one tick of the datapath. The unit enters the next control
// state and returns exactly one result transfer with that state's number and
// its control signals. The opcode is only looked at on the tick that leaves
// decode.
// The result of a transfer accepted at an edge is registered at that edge and
// valid from it on. Throughput is one transfer per cycle while the receiver
// takes results, set by the single result register that the state decode feeds.
// While the receiver stalls, the result register holds its transfer and the
// input stays ready until that register is full and not being drained.
// Reset puts the unit in fetch with the fetch selects held and the result
// register empty; the first transfer after reset enters decode.
// ----------------------------------------------------------------------------
module multicycle_mips_control_fsm_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  mmcf_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output mmcf_pkg::out_t out_data_o
);

  mmcf_pkg::state_e state_q, state_d;
  mmcf_pkg::hold_t  hold_q, hold_d;
  mmcf_pkg::out_t   result, out_data_q;
  logic             out_valid_q, out_valid_d;
  logic             in_accept;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_accept   = in_valid_i && in_ready_o;
  assign out_valid_d = in_accept || (out_valid_q && !out_ready_i);

  mmcf_next u_next (
    .state_q_i (state_q),
    .hold_q_i  (hold_q),
    .in_data_i (in_data_i),
    .state_d_o (state_d),
    .hold_d_o  (hold_d),
    .result_o  (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mmcf_pkg::ST_FETCH;
      hold_q      <= mmcf_pkg::HOLD_RESET;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_accept) begin
        state_q <= state_d;
        hold_q  <= hold_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== src/mmcf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmcf_checker
// Port-level checks of the multicycle MIPS control unit, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mmcf_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input mmcf_pkg::in_t  in_data_i,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input mmcf_pkg::out_t out_data_o
);

  // A stalled result transfer keeps its payload.
  `ASSERT_RST(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))

  // With no result pending the unit must take the next transfer.
  `ASSERT_RST(a_ready_when_empty, clk_i, rst_ni, !out_valid_o |-> in_ready_o)

  // Only fetch loads the instruction register, and it also reads memory and writes the PC.
  `ASSERT_RST(a_fetch_strobes, clk_i, rst_ni, out_valid_o |-> (out_data_o.ir_write == (out_data_o.state_id == 5'd0)) && (out_data_o.ir_write == 1'b0 || (out_data_o.memory_controls[1] && out_data_o.pc_controls[0])))

  // Memory is written only in the store state, with the data address selected.
  `ASSERT_RST(a_store_only, clk_i, rst_ni, out_valid_o && out_data_o.memory_controls[0] |-> out_data_o.state_id == 5'd5 && out_data_o.memory_controls[2])

endmodule

bind multicycle_mips_control_fsm_unit mmcf_checker u_mmcf_checker (.*);

// ===== tb/sv/control_unit_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// control_unit_checker
// Watches both channels of the multicycle MIPS control unit. It predicts the
// control word of every tick from its own copy of the state machine and
// compares each result transfer, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module control_unit_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_ready_i,
  input  mmcf_pkg::in_t  in_data_i,
  input  logic           out_valid_i,
  input  logic           out_ready_i,
  input  mmcf_pkg::out_t out_data_i,
  output int             errors_o,
  output int             pending_o
);

  typedef enum logic [4:0] {
    S_FETCH, S_DECODE, S_MEM_ADDR, S_MEM_READ, S_MEM_WB, S_MEM_WRITE,
    S_R_EXEC, S_R_DONE, S_BRANCH, S_JUMP, S_ADDIU_EXEC, S_IMM_DONE,
    S_ANDI_EXEC, S_LUI_EXEC, S_ORI_EXEC, S_SHIFT_EXEC, S_SHIFT_DONE
  } ctl_state_e;

  localparam logic [2:0] ALU_ADD   = 3'd0;
  localparam logic [2:0] ALU_SUB   = 3'd1;
  localparam logic [2:0] ALU_FUNCT = 3'd2;
  localparam logic [2:0] ALU_AND   = 3'd3;
  localparam logic [2:0] ALU_LUI   = 3'd4;
  localparam logic [2:0] ALU_OR    = 3'd5;

  localparam logic [1:0] A_PC    = 2'd0;
  localparam logic [1:0] A_REG   = 2'd1;
  localparam logic [1:0] A_SHAMT = 2'd2;

  localparam logic [1:0] B_REG    = 2'd0;
  localparam logic [1:0] B_FOUR   = 2'd1;
  localparam logic [1:0] B_IMM    = 2'd2;
  localparam logic [1:0] B_BRANCH = 2'd3;

  localparam logic [1:0] PCS_ALU    = 2'd0;
  localparam logic [1:0] PCS_TARGET = 2'd1;
  localparam logic [1:0] PCS_JUMP   = 2'd2;

  ctl_state_e     ctl_state;
  logic           store_path;
  logic [2:0]     alu_op;
  logic [1:0]     src_a;
  logic [1:0]     src_b;
  logic [1:0]     pc_src;
  logic           iord;
  logic           reg_dst;
  mmcf_pkg::out_t control_words_q[$];

  function automatic void set_alu(input logic [2:0] op, input logic [1:0] a,
                                  input logic [1:0] b);
    alu_op = op;
    src_a  = a;
    src_b  = b;
  endfunction

  // Advances the state machine by one tick and returns the control word.
  function automatic mmcf_pkg::out_t predict_tick(input mmcf_pkg::in_t item);
    mmcf_pkg::out_t res;
    ctl_state_e     nxt;
    logic           mem_rd;
    logic           mem_wr;
    logic           pc_cond;
    logic           pc_wr;
    logic           reg_wr;
    logic           mem_to_reg;
    logic           ir_ld;
    mem_rd     = 1'b0;
    mem_wr     = 1'b0;
    pc_cond    = 1'b0;
    pc_wr      = 1'b0;
    reg_wr     = 1'b0;
    mem_to_reg = 1'b0;
    ir_ld      = 1'b0;
    case (ctl_state)
      S_FETCH: nxt = S_DECODE;
      S_DECODE: begin
        store_path = 1'b0;
        case (item.opcode)
          mmcf_pkg::OP_LW: nxt = S_MEM_ADDR;
          mmcf_pkg::OP_SW: begin
            store_path = 1'b1;
            nxt = S_MEM_ADDR;
          end
          mmcf_pkg::OP_RTYPE: begin
            if (item.funct_code == mmcf_pkg::FN_SLL || item.funct_code == mmcf_pkg::FN_SRL)
              nxt = S_SHIFT_EXEC;
            else
              nxt = S_R_EXEC;
          end
          mmcf_pkg::OP_BEQ:   nxt = S_BRANCH;
          mmcf_pkg::OP_J:     nxt = S_JUMP;
          mmcf_pkg::OP_ADDIU: nxt = S_ADDIU_EXEC;
          mmcf_pkg::OP_ANDI:  nxt = S_ANDI_EXEC;
          mmcf_pkg::OP_LUI:   nxt = S_LUI_EXEC;
          mmcf_pkg::OP_ORI:   nxt = S_ORI_EXEC;
          default:            nxt = S_FETCH;
        endcase
      end
      S_MEM_ADDR: nxt = store_path ? S_MEM_WRITE : S_MEM_READ;
      S_MEM_READ: nxt = S_MEM_WB;
      S_R_EXEC:   nxt = S_R_DONE;
      S_ADDIU_EXEC, S_ANDI_EXEC, S_LUI_EXEC, S_ORI_EXEC: nxt = S_IMM_DONE;
      S_SHIFT_EXEC: nxt = S_SHIFT_DONE;
      default:    nxt = S_FETCH;
    endcase

    // Strobes come only from the state entered; the selects keep their value
    // unless that state drives them.
    case (nxt)
      S_FETCH: begin
        mem_rd = 1'b1;
        ir_ld  = 1'b1;
        pc_wr  = 1'b1;
        iord   = 1'b0;
        set_alu(ALU_ADD, A_PC, B_FOUR);
        pc_src = PCS_ALU;
      end
      S_DECODE:   set_alu(ALU_ADD, A_PC, B_BRANCH);
      S_MEM_ADDR: set_alu(ALU_ADD, A_REG, B_IMM);
      S_MEM_READ: begin
        mem_rd = 1'b1;
        iord   = 1'b1;
      end
      S_MEM_WB: begin
        reg_wr     = 1'b1;
        mem_to_reg = 1'b1;
        reg_dst    = 1'b0;
      end
      S_MEM_WRITE: begin
        mem_wr = 1'b1;
        iord   = 1'b1;
      end
      S_R_EXEC: set_alu(ALU_FUNCT, A_REG, B_REG);
      S_R_DONE: begin
        reg_wr  = 1'b1;
        reg_dst = 1'b1;
      end
      S_BRANCH: begin
        set_alu(ALU_SUB, A_REG, B_REG);
        pc_cond = 1'b1;
        pc_src  = PCS_TARGET;
      end
      S_JUMP: begin
        pc_wr  = 1'b1;
        pc_src = PCS_JUMP;
      end
      S_ADDIU_EXEC: set_alu(ALU_ADD, A_REG, B_IMM);
      S_IMM_DONE: begin
        reg_wr  = 1'b1;
        reg_dst = 1'b0;
      end
      S_ANDI_EXEC:  set_alu(ALU_AND, A_REG, B_IMM);
      S_LUI_EXEC:   set_alu(ALU_LUI, A_REG, B_IMM);
      S_ORI_EXEC:   set_alu(ALU_OR, A_REG, B_IMM);
      S_SHIFT_EXEC: set_alu(ALU_FUNCT, A_SHAMT, B_IMM);
      default: begin
        reg_wr  = 1'b1;
        reg_dst = 1'b1;
      end
    endcase
    ctl_state = nxt;

    res.state_id          = ctl_state;
    res.alu_op            = alu_op;
    res.alu_src_a         = src_a;
    res.alu_src_b         = src_b;
    res.pc_source         = pc_src;
    res.memory_controls   = {iord, mem_rd, mem_wr};
    res.pc_controls       = {pc_cond, pc_wr};
    res.register_controls = {reg_wr, mem_to_reg, reg_dst};
    res.ir_write          = ir_ld;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [4:0] want,
                             input logic [4:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    mmcf_pkg::out_t want;
    if (!rst_ni) begin
      ctl_state  = S_FETCH;
      store_path = 1'b0;
      set_alu(ALU_ADD, A_PC, B_FOUR);
      pc_src     = PCS_ALU;
      iord       = 1'b0;
      reg_dst    = 1'b0;
      errors_o   = 0;
      control_words_q.delete();
    end else begin
      // A result leaves only after the edge that registered its tick, so check it
      // before the prediction for this edge's input transfer is queued.
      if (out_valid_i && out_ready_i) begin
        if (control_words_q.size() == 0) begin
          $display("%0t: result transfer with no expectation, expected none, got %h",
                   $time, out_data_i);
          errors_o++;
        end else begin
          want = control_words_q.pop_front();
          check_field("state_id", want.state_id, out_data_i.state_id);
          check_field("alu_op", 5'(want.alu_op), 5'(out_data_i.alu_op));
          check_field("alu_src_a", 5'(want.alu_src_a), 5'(out_data_i.alu_src_a));
          check_field("alu_src_b", 5'(want.alu_src_b), 5'(out_data_i.alu_src_b));
          check_field("pc_source", 5'(want.pc_source), 5'(out_data_i.pc_source));
          check_field("memory_controls", 5'(want.memory_controls),
                      5'(out_data_i.memory_controls));
          check_field("pc_controls", 5'(want.pc_controls),
                      5'(out_data_i.pc_controls));
          check_field("register_controls", 5'(want.register_controls),
                      5'(out_data_i.register_controls));
          check_field("ir_write", 5'(want.ir_write), 5'(out_data_i.ir_write));
        end
      end
      if (in_valid_i && in_ready_i)
        control_words_q.push_back(predict_tick(in_data_i));
    end
    pending_o = control_words_q.size();
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives instruction ticks into the multicycle MIPS control unit: a directed
// walk through every instruction path, then random instruction streams with
// noise, under random idling on both channels. The checker beside the unit
// predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;

  localparam int TICK_TARGET = 1300;
  localparam int STALL_LIMIT = 2000;

  logic           clk = 1'b0;
  logic           rst_n;
  logic           in_valid;
  logic           in_ready;
  mmcf_pkg::in_t  in_data;
  logic           out_valid;
  logic           out_ready = 1'b0;
  mmcf_pkg::out_t out_data;
  logic           steady;
  int             errors;
  int             pending;
  int             ticks_sent;
  int             stall_cycles = 0;

  multicycle_mips_control_fsm_unit u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  control_unit_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  always #10 clk = ~clk;

  always @(negedge clk) begin
    if (!rst_n)
      out_ready <= 1'b0;
    else
      out_ready <= steady || ($urandom_range(0, 99) >= 27);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Entered and left at a falling edge; holds valid until the transfer.
  task automatic send_tick(input logic [5:0] op, input logic [5:0] fn);
    while (!steady && $urandom_range(0, 99) < 27) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{opcode: op, funct_code: fn};
    do
      @(posedge clk);
    while (!in_ready);
    ticks_sent++;
    @(negedge clk);
  endtask

  // Ticks that follow the decode tick until fetch is entered again.
  function automatic int ticks_after_decode(input logic [5:0] op);
    case (op)
      mmcf_pkg::OP_LW: return 3;
      mmcf_pkg::OP_SW, mmcf_pkg::OP_RTYPE, mmcf_pkg::OP_ADDIU,
      mmcf_pkg::OP_ANDI, mmcf_pkg::OP_LUI, mmcf_pkg::OP_ORI: return 2;
      mmcf_pkg::OP_BEQ, mmcf_pkg::OP_J: return 1;
      default: return 0;
    endcase
  endfunction

  // One instruction from fetch back to fetch. Directed runs put all-ones on
  // the fetch tick and zeros on the path ticks, where the fields are ignored.
  task automatic run_instruction(input logic [5:0] op, input logic [5:0] fn,
                                 input logic directed);
    int rest;
    rest = ticks_after_decode(op);
    if (directed)
      send_tick(6'h3f, 6'h3f);
    else
      send_tick(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
    send_tick(op, fn);
    repeat (rest) begin
      if (directed)
        send_tick(6'h00, 6'h00);
      else
        send_tick(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
    end
  endtask

  logic [5:0] known_ops [9];

  initial begin
    logic [5:0] op;
    logic [5:0] fn;
    int         n_instr;
    known_ops = '{mmcf_pkg::OP_LW, mmcf_pkg::OP_SW, mmcf_pkg::OP_RTYPE,
                  mmcf_pkg::OP_J, mmcf_pkg::OP_BEQ, mmcf_pkg::OP_ADDIU,
                  mmcf_pkg::OP_ANDI, mmcf_pkg::OP_LUI, mmcf_pkg::OP_ORI};
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    steady       = 1'b0;
    ticks_sent   = 0;
    n_instr      = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Every path once, both shift functs, a plain R-type and an unknown opcode.
    run_instruction(mmcf_pkg::OP_LW, 6'h3f, 1'b1);
    run_instruction(mmcf_pkg::OP_SW, 6'h00, 1'b1);
    run_instruction(mmcf_pkg::OP_RTYPE, mmcf_pkg::FN_SRL, 1'b1);
    run_instruction(mmcf_pkg::OP_RTYPE, mmcf_pkg::FN_SLL, 1'b1);
    run_instruction(mmcf_pkg::OP_RTYPE, 6'h3f, 1'b1);
    run_instruction(mmcf_pkg::OP_BEQ, 6'h00, 1'b1);
    run_instruction(mmcf_pkg::OP_J, 6'h00, 1'b1);
    run_instruction(mmcf_pkg::OP_ADDIU, 6'h00, 1'b1);
    run_instruction(mmcf_pkg::OP_ANDI, 6'h00, 1'b1);
    run_instruction(mmcf_pkg::OP_LUI, 6'h00, 1'b1);
    run_instruction(mmcf_pkg::OP_ORI, 6'h00, 1'b1);
    run_instruction(6'h3f, 6'h3f, 1'b1);

    while (ticks_sent < TICK_TARGET) begin
      // Once, let the unit drain completely before carrying on.
      if (n_instr == 60) begin
        in_valid <= 1'b0;
        while (pending != 0)
          @(negedge clk);
      end
      steady <= (ticks_sent >= 500 && ticks_sent < 700);
      if ($urandom_range(0, 99) < 88)
        op = known_ops[$urandom_range(0, 8)];
      else
        op = 6'($urandom_range(0, 63));
      if (op == mmcf_pkg::OP_RTYPE && $urandom_range(0, 1) == 1)
        fn = $urandom_range(0, 1) ? mmcf_pkg::FN_SLL : mmcf_pkg::FN_SRL;
      else
        fn = 6'($urandom_range(0, 63));
      run_instruction(op, fn, 1'b0);
      n_instr++;
    end
    in_valid <= 1'b0;
    steady   <= 1'b0;

    while (pending != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/mmcf_pkg.sv
src/mmcf_next.sv
src/multicycle_mips_control_fsm_unit.sv
src/mmcf_checker.sv
tb/sv/control_unit_checker.sv
tb/sv/testbench.sv
